// File: hw/rtl/slfp_pkg.sv
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared constants and helpers for the sync-word / length-prefixed frame
// parser: register indexes, count limits and clamping of the count registers.
// ----------------------------------------------------------------------------
package slfp_pkg;

	// limits on signature and length field sizes
	localparam int MAX_SIG_BYTES = 4;
	localparam int MAX_LEN_BYTES = 4;

	// bytes held in the signature register
	localparam int SIG_WORD_BYTES = 4;

	// counter widths
	localparam int SIG_CNT_W = $clog2(MAX_SIG_BYTES + 1);
	localparam int LEN_LIM_W = $clog2(MAX_LEN_BYTES + 1);
	localparam int LEN_SEEN_W = 3;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_SIG_BYTES = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SIG_LEN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_LEN_FIELD_BYTES = CFG_IDX_W'(2);

	// register reset values
	localparam logic [31:0] SIG_BYTES_RST = 32'h0000_0000;
	localparam logic [2:0] SIG_LEN_RST = 3'd1;
	localparam logic [2:0] LEN_FIELD_BYTES_RST = 3'd2;

	// signature length, clamped to the supported maximum
	function automatic logic [SIG_CNT_W-1:0] eff_sig_len(input logic [2:0] sig_len);
		if (int'(sig_len) > MAX_SIG_BYTES) begin
			return SIG_CNT_W'(MAX_SIG_BYTES);
		end
		return SIG_CNT_W'(sig_len);
	endfunction

	// length field size, clamped to the supported maximum
	function automatic logic [LEN_LIM_W-1:0] eff_len_bytes(input logic [2:0] len_bytes);
		if (int'(len_bytes) > MAX_LEN_BYTES) begin
			return LEN_LIM_W'(MAX_LEN_BYTES);
		end
		return LEN_LIM_W'(len_bytes);
	endfunction

	// signature byte at a position; positions past the register read as zero
	function automatic logic [7:0] sig_byte_at(input logic [31:0] sig,
			input logic [SIG_CNT_W-1:0] idx);
		logic [7:0] r;
		r = 8'h00;
		for (int k = 0; k < SIG_WORD_BYTES; k++) begin
			if (int'(idx) == k) begin
				r = sig[8*k +: 8];
			end
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/sync_length_frame_parser.sv
// ----------------------------------------------------------------------------
// sync_length_frame_parser
// Hunts for a signature in a byte stream, gathers a big-endian length field
// and streams the payload bytes out, marking the last; a zero length gives an
// empty-message marker as the length field completes (at once if none).
// Throughput: one byte per cycle while the skid is empty; the per-byte
// compare, shift-or and decrement sit between the state registers and the
// result register. A two-entry output (result register plus skid, which
// takes a result while the output is held) keeps in_ready registered.
// Reset: arst_n clears state, registers and outputs at once; no clearing pass.
// ----------------------------------------------------------------------------
module sync_length_frame_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [slfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slfp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// input byte stream
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        rx_byte,
	// result stream
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        payload_byte,
	output logic                              empty_message,
	output logic                              last_of_message
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_v;
		logic       empty;
		logic       last;
	} res_t;

	// configuration registers
	logic [31:0] sig_bytes_q;
	logic [2:0]  sig_len_q;
	logic [2:0]  len_field_bytes_q;

	// parser state
	phase_t                             phase_q, phase_d;
	logic [slfp_pkg::SIG_CNT_W-1:0]     sig_matched_q, sig_matched_d;
	logic [slfp_pkg::LEN_SEEN_W-1:0]    len_seen_q, len_seen_d;
	logic [31:0]                        len_accum_q, len_accum_d;
	logic [31:0]                        bytes_rem_q, bytes_rem_d;

	// output register and skid stage
	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;

	// per-byte results
	res_t res_c;
	logic res_valid_c;
	logic accept;

	logic [slfp_pkg::SIG_CNT_W-1:0]  slen;
	logic [slfp_pkg::LEN_LIM_W-1:0]  llen;
	logic [slfp_pkg::SIG_CNT_W-1:0]  matched_next;
	logic [31:0]                     len_base;
	logic [slfp_pkg::LEN_SEEN_W-1:0] seen_base;
	logic [31:0]                     len_new;
	logic [slfp_pkg::LEN_SEEN_W-1:0] seen_new;
	logic                            len_done;

	assign accept = in_valid & in_ready;
	assign slen = slfp_pkg::eff_sig_len(sig_len_q);
	assign llen = slfp_pkg::eff_len_bytes(len_field_bytes_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_bytes_q       <= slfp_pkg::SIG_BYTES_RST;
			sig_len_q         <= slfp_pkg::SIG_LEN_RST;
			len_field_bytes_q <= slfp_pkg::LEN_FIELD_BYTES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slfp_pkg::CFG_SIG_BYTES:       sig_bytes_q <= cfg_wdata;
				slfp_pkg::CFG_SIG_LEN:         sig_len_q <= cfg_wdata[2:0];
				slfp_pkg::CFG_LEN_FIELD_BYTES: len_field_bytes_q <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// signature progress: advance on a match, else restart against byte 0
	always_comb begin
		if (slfp_pkg::sig_byte_at(sig_bytes_q, sig_matched_q) == rx_byte) begin
			matched_next = sig_matched_q + slfp_pkg::SIG_CNT_W'(1);
		end else if (slfp_pkg::sig_byte_at(sig_bytes_q, '0) == rx_byte) begin
			matched_next = slfp_pkg::SIG_CNT_W'(1);
		end else begin
			matched_next = '0;
		end
	end

	// length byte intake; a byte taken straight from the hunt starts from zero
	always_comb begin
		if (phase_q == PH_LEN) begin
			len_base  = len_accum_q;
			seen_base = len_seen_q;
		end else begin
			len_base  = '0;
			seen_base = '0;
		end
		len_new  = {len_base[23:0], rx_byte};
		seen_new = (seen_base < 3'd7) ? seen_base + 3'd1 : seen_base;
		len_done = int'(seen_new) >= int'(llen);
	end

	// next state and result for one byte
	always_comb begin
		phase_d       = phase_q;
		sig_matched_d = sig_matched_q;
		len_seen_d    = len_seen_q;
		len_accum_d   = len_accum_q;
		bytes_rem_d   = bytes_rem_q;
		res_valid_c   = 1'b0;
		res_c         = '0;

		unique case (phase_q)
			PH_HUNT: begin
				if (int'(sig_matched_q) >= int'(slen) ||
						int'(matched_next) >= int'(slen)) begin
					// signature complete (or already met / empty)
					sig_matched_d = '0;
					len_accum_d   = '0;
					len_seen_d    = '0;
					phase_d       = PH_LEN;
					if (llen == '0) begin
						// no length field: empty message at once
						phase_d     = PH_HUNT;
						res_valid_c = 1'b1;
						res_c.empty = 1'b1;
						res_c.last  = 1'b1;
					end else if (int'(sig_matched_q) >= int'(slen)) begin
						// this byte already belongs to the length field
						if (len_done) begin
							if (len_new == '0) begin
								phase_d     = PH_HUNT;
								res_valid_c = 1'b1;
								res_c.empty = 1'b1;
								res_c.last  = 1'b1;
							end else begin
								bytes_rem_d = len_new;
								phase_d     = PH_DATA;
							end
						end else begin
							len_accum_d = len_new;
							len_seen_d  = seen_new;
						end
					end
				end else begin
					sig_matched_d = matched_next;
				end
			end
			PH_LEN: begin
				if (len_done) begin
					len_accum_d = '0;
					len_seen_d  = '0;
					if (len_new == '0) begin
						phase_d     = PH_HUNT;
						res_valid_c = 1'b1;
						res_c.empty = 1'b1;
						res_c.last  = 1'b1;
					end else begin
						bytes_rem_d = len_new;
						phase_d     = PH_DATA;
					end
				end else begin
					len_accum_d = len_new;
					len_seen_d  = seen_new;
				end
			end
			PH_DATA: begin
				if (bytes_rem_q == '0) begin
					phase_d = PH_HUNT;
				end else begin
					bytes_rem_d  = bytes_rem_q - 32'd1;
					res_valid_c  = 1'b1;
					res_c.byte_v = rx_byte;
					if (bytes_rem_q == 32'd1) begin
						res_c.last = 1'b1;
						phase_d    = PH_HUNT;
					end
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			sig_matched_q <= '0;
			len_seen_q    <= '0;
			len_accum_q   <= '0;
			bytes_rem_q   <= '0;
		end else if (accept) begin
			phase_q       <= phase_d;
			sig_matched_q <= sig_matched_d;
			len_seen_q    <= len_seen_d;
			len_accum_q   <= len_accum_d;
			bytes_rem_q   <= bytes_rem_d;
		end
	end

	// output register with skid stage: a new request lands in the skid
	// only while the output register is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept & res_valid_c;
			end
		end else if (accept && res_valid_c) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload of the two output entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= '0;
			skid_q <= '0;
		end else if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res_c;
		end else if (accept && res_valid_c) begin
			skid_q <= res_c;
		end
	end

	assign in_ready        = ~skid_valid_q;
	assign out_valid       = out_valid_q;
	assign payload_byte    = out_q.byte_v;
	assign empty_message   = out_q.empty;
	assign last_of_message = out_q.last;

endmodule

// File: hw/rtl/slfp_checker.sv
// ----------------------------------------------------------------------------
// slfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module slfp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic [slfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [slfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [7:0]                      rx_byte,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [7:0]                      payload_byte,
	input logic                            empty_message,
	input logic                            last_of_message
);

	// no result is shown while in reset
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// input stalls only when a result is already waiting
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// empty-message marker ends its message and carries a zero byte
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_message) |-> (last_of_message && payload_byte == 8'h00))
		else $error("malformed empty-message result");

	// a held request keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(payload_byte) &&
		$stable(empty_message) && $stable(last_of_message)))
		else $error("stalled result changed");

endmodule

bind sync_length_frame_parser slfp_checker u_slfp_checker (.*);

// File: bench/slfp_frame_checker.sv
// ----------------------------------------------------------------------------
// slfp_frame_checker
// Watches the configuration port and both byte channels of the frame parser.
// Keeps its own copy of the registers and parse state, works out the result
// of every accepted request and compares each result leaving the block with
// the oldest one still owed. Hands the failure count and the number of
// results still owed to the testbench top.
// ----------------------------------------------------------------------------
module slfp_frame_checker
	import slfp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [7:0]             rx_byte,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [7:0]             payload_byte,
	input  logic                   empty_message,
	input  logic                   last_of_message,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] payload;
		logic       empty;
		logic       last;
	} frame_out_t;

	typedef enum logic [1:0] {HUNTING, LENGTH, PAYLOAD} parse_phase_t;

	// register copies
	logic [31:0]  sig_word;
	logic [2:0]   sig_count_reg;
	logic [2:0]   len_count_reg;

	// parse state
	parse_phase_t phase;
	logic [2:0]   sig_hits;
	logic [2:0]   len_seen;
	logic [31:0]  len_acc;
	logic [31:0]  payload_left;

	frame_out_t   frame_bytes_due[$];
	int           fails;

	// signature byte by position; past the register it reads as zero
	function automatic logic [7:0] sig_byte(input int idx);
		if (idx >= SIG_WORD_BYTES) begin
			return 8'h00;
		end
		return sig_word[8*idx +: 8];
	endfunction

	// length field done: start the payload, or owe an empty message
	function automatic bit close_length(output frame_out_t r);
		logic [31:0] n;
		n = len_acc;
		len_acc = '0;
		len_seen = '0;
		r = '0;
		if (n == 0) begin
			phase = HUNTING;
			r.empty = 1'b1;
			r.last = 1'b1;
			return 1'b1;
		end
		payload_left = n;
		phase = PAYLOAD;
		return 1'b0;
	endfunction

	// signature done; a zero-byte length field closes at once
	function automatic bit open_length(input int lim, output frame_out_t r);
		sig_hits = '0;
		len_acc = '0;
		len_seen = '0;
		phase = LENGTH;
		r = '0;
		if (lim == 0) begin
			return close_length(r);
		end
		return 1'b0;
	endfunction

	// big-endian shift-in of one length byte
	function automatic bit take_length(input logic [7:0] b, input int lim,
			output frame_out_t r);
		len_acc = {len_acc[23:0], b};
		if (len_seen < 3'd7) begin
			len_seen++;
		end
		r = '0;
		if (int'(len_seen) >= lim) begin
			return close_length(r);
		end
		return 1'b0;
	endfunction

	// one received byte; returns 1 when it owes a result
	function automatic bit parse_rx_byte(input logic [7:0] b, output frame_out_t r);
		int slen;
		int lim;
		slen = (int'(sig_count_reg) > MAX_SIG_BYTES) ? MAX_SIG_BYTES : int'(sig_count_reg);
		lim = (int'(len_count_reg) > MAX_LEN_BYTES) ? MAX_LEN_BYTES : int'(len_count_reg);
		r = '0;
		case (phase)
			HUNTING: begin
				// empty or already met signature: byte goes to the length field
				if (int'(sig_hits) >= slen) begin
					if (open_length(lim, r)) begin
						return 1'b1;
					end
					return take_length(b, lim, r);
				end
				// naive restart: compare only with the first byte on a miss
				if (sig_byte(int'(sig_hits)) == b) begin
					sig_hits++;
				end else begin
					sig_hits = (sig_byte(0) == b) ? 3'd1 : 3'd0;
				end
				if (int'(sig_hits) >= slen) begin
					return open_length(lim, r);
				end
				return 1'b0;
			end
			LENGTH: begin
				return take_length(b, lim, r);
			end
			PAYLOAD: begin
				if (payload_left == 0) begin
					phase = HUNTING;
					return 1'b0;
				end
				payload_left--;
				r.payload = b;
				r.last = (payload_left == 0);
				if (payload_left == 0) begin
					phase = HUNTING;
				end
				return 1'b1;
			end
			default: begin
				phase = HUNTING;
				return 1'b0;
			end
		endcase
	endfunction

	// track requests, results and register writes
	always @(posedge clk or negedge arst_n) begin : track
		frame_out_t want;
		if (!arst_n) begin
			sig_word = SIG_BYTES_RST;
			sig_count_reg = SIG_LEN_RST;
			len_count_reg = LEN_FIELD_BYTES_RST;
			phase = HUNTING;
			sig_hits = '0;
			len_seen = '0;
			len_acc = '0;
			payload_left = '0;
			frame_bytes_due.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// result leaving the block
			if (out_valid && out_ready) begin
				if (frame_bytes_due.size() == 0) begin
					fails++;
					$error("unexpected result: payload_byte %02h empty_message %0b last_of_message %0b",
						payload_byte, empty_message, last_of_message);
				end else begin
					want = frame_bytes_due.pop_front();
					if (payload_byte !== want.payload) begin
						fails++;
						$error("payload_byte: expected %02h, got %02h", want.payload, payload_byte);
					end
					if (empty_message !== want.empty) begin
						fails++;
						$error("empty_message: expected %0b, got %0b", want.empty, empty_message);
					end
					if (last_of_message !== want.last) begin
						fails++;
						$error("last_of_message: expected %0b, got %0b", want.last,
							last_of_message);
					end
				end
			end
			// accepted byte request
			if (in_valid && in_ready) begin
				if (parse_rx_byte(rx_byte, want)) begin
					frame_bytes_due = {frame_bytes_due, want};
				end
			end
			// register write
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIG_BYTES:       sig_word = cfg_wdata[31:0];
					CFG_SIG_LEN:         sig_count_reg = cfg_wdata[2:0];
					CFG_LEN_FIELD_BYTES: len_count_reg = cfg_wdata[2:0];
					default: ;
				endcase
			end
			fail_count <= fails;
			pending <= frame_bytes_due.size();
		end
	end

endmodule

// File: bench/tb_sync_length_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_sync_length_frame_parser
// Drives byte requests into the frame parser with random gaps and random
// result back-pressure. A directed opening covers naive restart, empty
// signature, empty length field, both empty, clamped counts and a count
// change part-way through a signature; then random phases over several
// register settings send mostly well-formed frames with random content,
// plus noise and broken signatures. Checking sits in slfp_frame_checker.
// ----------------------------------------------------------------------------
module tb_sync_length_frame_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import slfp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            rx_byte = 8'h00;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            payload_byte;
	logic                  empty_message;
	logic                  last_of_message;

	int fails;
	int pending;

	// stimulus bookkeeping
	logic [31:0] cur_sig = SIG_BYTES_RST;
	int          cur_slen = 1;
	int          cur_lbytes = 2;
	int          sent = 0;
	int          calm_items = 0;
	int          hold_req = 0;
	int          hold_served = 0;
	int          quiet = 0;

	always #5 clk = ~clk;

	sync_length_frame_parser uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.payload_byte    (payload_byte),
		.empty_message   (empty_message),
		.last_of_message (last_of_message)
	);

	slfp_frame_checker frame_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.payload_byte    (payload_byte),
		.empty_message   (empty_message),
		.last_of_message (last_of_message),
		.fail_count      (fails),
		.pending         (pending)
	);

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// payload length for the current length field size
	function automatic logic [31:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (cur_lbytes == 0 || r < 10) begin
			return 32'd0;
		end
		if (r < 90) begin
			return 32'($urandom_range(1, 10));
		end
		return 32'($urandom_range(11, 48));
	endfunction

	// random byte that differs from both given bytes
	function automatic logic [7:0] byte_other_than(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] v;
		do begin
			v = 8'($urandom());
		end while (v == a || v == b);
		return v;
	endfunction

	// one byte request, held until accepted
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (calm_items > 0) begin
			calm_items--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 59) == 0) begin
				calm_items = $urandom_range(30, 120);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// stop sending and wait for every owed result, plus a little slack
	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// write all three registers while the block is idle
	task automatic set_cfg(input logic [31:0] sig, input logic [2:0] slen,
			input logic [2:0] lbytes);
		wait_for_quiet();
		cfg_we <= 1'b1;
		cfg_index <= CFG_SIG_BYTES;
		cfg_wdata <= sig;
		@(posedge clk);
		// junk above the count bits is ignored
		cfg_index <= CFG_SIG_LEN;
		cfg_wdata <= ($urandom() & 32'hFFFF_FFF8) | 32'(slen);
		@(posedge clk);
		cfg_index <= CFG_LEN_FIELD_BYTES;
		cfg_wdata <= ($urandom() & 32'hFFFF_FFF8) | 32'(lbytes);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_sig = sig;
		cur_slen = (int'(slen) > MAX_SIG_BYTES) ? MAX_SIG_BYTES : int'(slen);
		cur_lbytes = (int'(lbytes) > MAX_LEN_BYTES) ? MAX_LEN_BYTES : int'(lbytes);
	endtask

	// signature, big-endian length, random payload
	task automatic send_frame(input logic [31:0] len);
		for (int k = 0; k < cur_slen; k++) begin
			send_byte(cur_sig[8*k +: 8]);
		end
		for (int k = cur_lbytes - 1; k >= 0; k--) begin
			send_byte(len[8*k +: 8]);
		end
		for (int k = 0; k < int'(len); k++) begin
			send_byte(8'($urandom()));
		end
	endtask

	// receiver: random stalls, calm stretches and the requested long hold
	initial begin : result_sink
		int stall;
		int calm;
		calm = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req != hold_served) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served = hold_req;
			end else if (calm > 0) begin
				calm--;
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				stall = pick_gap();
				if ($urandom_range(0, 49) == 0) begin
					calm = $urandom_range(40, 150);
				end
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		int r;
		int goal;
		int k;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero signature byte, two-byte zero length
		send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);

		// four-byte signature with a naive restart on the repeated first byte
		set_cfg(32'hFF00_AA55, 3'd4, 3'd1);
		send_byte(8'h55); send_byte(8'h55); send_byte(8'hAA); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'h02); send_byte(8'hFF); send_byte(8'h00);

		// empty signature: first byte is already length
		set_cfg(32'h0000_0000, 3'd0, 3'd1);
		send_byte(8'h01); send_byte(8'h7E);

		// empty length field: signature alone reports an empty message
		set_cfg(32'h0000_0081, 3'd1, 3'd0);
		send_byte(8'h81);

		// both empty: every byte is an empty message
		set_cfg(32'hFFFF_FFFF, 3'd0, 3'd0);
		send_byte(8'hFF); send_byte(8'h00);

		// oversized counts clamp to four
		set_cfg(32'h1234_5678, 3'd7, 3'd7);
		send_byte(8'h78); send_byte(8'h56); send_byte(8'h34); send_byte(8'h12);
		send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h01);
		send_byte(8'h80);

		// signature count lowered after one byte matched
		set_cfg(32'h0000_C33C, 3'd2, 3'd1);
		send_byte(8'h3C);
		set_cfg(32'h0000_C33C, 3'd1, 3'd1);
		send_byte(8'h01); send_byte(8'hA7);

		// random phases over several settings
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_cfg($urandom(), 3'd4, 3'd2);
				1: set_cfg(32'h0000_0000, 3'd0, 3'd1);
				2: set_cfg(32'hFFFF_FFFF, 3'd1, 3'd0);
				3: set_cfg($urandom(), 3'd7, 3'd7);
				4: set_cfg($urandom(), 3'd0, 3'd0);
				5: set_cfg($urandom(), 3'd2, 3'd1);
				6: set_cfg($urandom(), 3'd3, 3'd4);
				default: set_cfg($urandom(), 3'd5, 3'd3);
			endcase
			goal = sent + ((p == 4) ? 60 : 135);
			if (p == 0) begin
				// receiver holds off through a long frame so the block backs up
				hold_req++;
				send_frame(32'd60);
			end
			while (sent < goal) begin
				r = $urandom_range(0, 99);
				if (cur_slen == 0 && cur_lbytes == 0) begin
					send_byte(8'($urandom()));
				end else if (r < 80 || cur_slen == 0) begin
					send_frame(pick_len());
				end else if (r < 90 || cur_slen == 1) begin
					// noise that never starts a signature
					repeat ($urandom_range(1, 5)) begin
						send_byte(byte_other_than(cur_sig[7:0], cur_sig[7:0]));
					end
				end else begin
					// signature cut short by a byte that restarts the hunt
					k = $urandom_range(1, cur_slen - 1);
					for (int i = 0; i < k; i++) begin
						send_byte(cur_sig[8*i +: 8]);
					end
					send_byte(byte_other_than(cur_sig[8*k +: 8], cur_sig[7:0]));
				end
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
